/* rtl/core/lppd_pkg.sv */
`timescale 1ns / 1ps

package lppd_pkg;

   // Event codes carried on the mode field of an input item.
   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_CLOSE = 2'd1;
   localparam logic [1:0] MODE_OPEN  = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_EMPTY    = 2'd1;
   localparam logic [1:0] KIND_OVERSIZE = 2'd2;
   localparam logic [1:0] KIND_ENDED    = 2'd3;

   // The length header is four bytes, most significant byte first.
   localparam int unsigned HEADER_BYTES = 4;
   localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);
   localparam int unsigned LENGTH_W     = 8 * HEADER_BYTES;

   localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last_flag;
   } result_type;

endpackage

/* rtl/core/length_prefixed_packet_deframer.sv */
`timescale 1ns / 1ps

// Length-prefixed packet deframer. Each input item is one received byte or a
// connection event (close or open). The block gathers a four-byte big-endian
// length header, then passes that many payload bytes out as items of kind
// payload, with last_flag set on the final one. A zero-length header gives a
// single empty-packet item with last_flag set. A header larger than
// MAX_PACKET_BYTES gives an oversize-error item, resets the parser and takes
// the link down. A close event resets the parser, takes the link down and
// gives a connection-ended item; an open event brings the link back up and
// gives nothing. Bytes that arrive while the link is down, and the unused
// mode code, are dropped without a result. One item is taken per clock while
// req_ready is high: all parsing is a single counter and compare update done
// at the accept edge. The result is registered into the output register, or
// into one skid register behind it while the output is full and not taken,
// so req_ready stays high while one result waits to be taken and drops only
// when both are full. No clearing pass follows reset; items are taken at once.
module length_prefixed_packet_deframer
   import lppd_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = 65536
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_rx_byte,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_flag
);

   // The payload counter only has to reach the largest legal length.
   localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_PACKET_BYTES);

   // Parser state.
   logic                 in_payload_ff,    in_payload_in;
   logic [HDR_CNT_W-1:0] header_count_ff,  header_count_in;
   logic [LENGTH_W-1:0]  length_accum_ff,  length_accum_in;
   logic [CNT_W-1:0]     payload_count_ff, payload_count_in;
   logic                 link_down_ff,     link_down_in;

   // Result side: output register and skid register.
   logic       out_valid_ff,  out_valid_in;
   result_type out_data_ff,   out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   logic       accept;
   logic       take;
   logic       res_valid;
   result_type res_data;

   logic [LENGTH_W-1:0] header_word;
   logic [CNT_W-1:0]    count_next;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = out_valid_ff && rsp_ready;

   assign header_word = {length_accum_ff[LENGTH_W-9:0], req_rx_byte};
   assign count_next  = payload_count_ff + CNT_W'(1);

   // Parser: next state and the result, if any, caused by the accepted item.
   always_comb begin
      in_payload_in    = in_payload_ff;
      header_count_in  = header_count_ff;
      length_accum_in  = length_accum_ff;
      payload_count_in = payload_count_ff;
      link_down_in     = link_down_ff;
      res_valid        = 1'b0;
      res_data         = '{kind: KIND_PAYLOAD, out_byte: 8'd0, last_flag: 1'b0};

      if (accept) begin
         case (req_mode)
            MODE_CLOSE: begin
               in_payload_in      = 1'b0;
               header_count_in    = '0;
               length_accum_in    = '0;
               payload_count_in   = '0;
               link_down_in       = 1'b1;
               res_valid          = 1'b1;
               res_data.kind      = KIND_ENDED;
            end
            MODE_OPEN: begin
               link_down_in = 1'b0;
            end
            MODE_BYTE: begin
               if (!link_down_ff) begin
                  if (!in_payload_ff) begin
                     length_accum_in = header_word;
                     header_count_in = header_count_ff + HDR_CNT_W'(1);
                     if (header_count_ff == HDR_LAST) begin
                        if (header_word == '0) begin
                           length_accum_in    = '0;
                           res_valid          = 1'b1;
                           res_data.kind      = KIND_EMPTY;
                           res_data.last_flag = 1'b1;
                        end else if (header_word > MAX_LEN) begin
                           length_accum_in = '0;
                           link_down_in    = 1'b1;
                           res_valid       = 1'b1;
                           res_data.kind   = KIND_OVERSIZE;
                        end else begin
                           in_payload_in    = 1'b1;
                           payload_count_in = '0;
                        end
                     end
                  end else begin
                     // The length never exceeds MAX_LEN here, so the count
                     // widened to the header width compares exactly.
                     res_valid         = 1'b1;
                     res_data.out_byte = req_rx_byte;
                     payload_count_in  = count_next;
                     if (LENGTH_W'(count_next) >= length_accum_ff) begin
                        in_payload_in      = 1'b0;
                        header_count_in    = '0;
                        length_accum_in    = '0;
                        payload_count_in   = '0;
                        res_data.last_flag = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // The unused mode code is dropped.
            end
         endcase
      end
   end

   // Result staging. The skid register fills only when a result arrives
   // while the output register is full and not being taken.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res_data;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff    <= 1'b0;
         header_count_ff  <= '0;
         length_accum_ff  <= '0;
         payload_count_ff <= '0;
         link_down_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         in_payload_ff    <= in_payload_in;
         header_count_ff  <= header_count_in;
         length_accum_ff  <= length_accum_in;
         payload_count_ff <= payload_count_in;
         link_down_ff     <= link_down_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_data_ff.kind;
   assign rsp_out_byte  = out_data_ff.out_byte;
   assign rsp_last_flag = out_data_ff.last_flag;

`ifndef SYNTH
   // The skid register is only ever filled behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output is empty");

   // While passing payload, the header counter is parked and the length is
   // a legal, nonzero packet length that the count has not yet reached.
   a_payload_length: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (header_count_ff == '0) && (length_accum_ff != '0)
         && (length_accum_ff <= MAX_LEN)
         && (LENGTH_W'(payload_count_ff) < length_accum_ff))
      else $error("payload phase entered with a bad length or count");

   // Only payload results carry a byte.
   a_byte_only_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_PAYLOAD) |-> rsp_out_byte == 8'd0)
      else $error("non-payload result carries a data byte");

   // An oversize header or a close event leaves the link down.
   a_down_after_error: assert property (@(posedge clock) disable iff (reset)
      res_valid && ((res_data.kind == KIND_OVERSIZE) || (res_data.kind == KIND_ENDED))
      |=> link_down_ff && !in_payload_ff)
      else $error("link not down after an error or close");
`endif

endmodule
